FILE: hdl/cvkf_pkg.sv
// ----------------------------------------------------------------------------
// cvkf_pkg
// Shared types, codes and saturation helpers for the track filter.
// ----------------------------------------------------------------------------
package cvkf_pkg;

    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] wide_t;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_VEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_VY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MIN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MAX  = 3'd7;

    localparam logic [1:0] MODE_INIT    = 2'd0;
    localparam logic [1:0] MODE_PREDICT = 2'd1;
    localparam logic [1:0] MODE_UPDATE  = 2'd2;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    function automatic wide_t ext(input word_t w);
        return {{32{w[31]}}, w};
    endfunction

    function automatic word_t sat32(input wide_t v);
        word_t r;
        if (v > ext(WORD_MAX)) begin
            r = WORD_MAX;
        end else if (v < ext(WORD_MIN)) begin
            r = WORD_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic class_valid(input logic [4:0] c);
        return (c >= 5'd1 && c <= 5'd7) || (c >= 5'd15 && c <= 5'd17) ||
               (c >= 5'd20 && c <= 5'd21);
    endfunction

endpackage

FILE: hdl/cvkf_mul.sv
// ----------------------------------------------------------------------------
// cvkf_mul
// Shared 32x32 multiplier: registered product, then rounded fixed point.
// ----------------------------------------------------------------------------
module cvkf_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic            aclk,
    input  cvkf_pkg::word_t a,
    input  cvkf_pkg::word_t b,
    output cvkf_pkg::wide_t prod,
    output cvkf_pkg::wide_t rnd
);
    import cvkf_pkg::*;

    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

    wide_t       p_reg;
    wide_t       rnd_reg;
    logic [63:0] mag;
    logic [63:0] mag_r;

    always_comb begin
        mag   = p_reg[63] ? (~p_reg + 64'd1) : p_reg;
        mag_r = (mag + HALF) >> FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        p_reg   <= a * b;
        rnd_reg <= p_reg[63] ? -$signed(mag_r) : $signed(mag_r);
    end

    assign prod = p_reg;
    assign rnd  = rnd_reg;

endmodule

FILE: hdl/cvkf_div.sv
// ----------------------------------------------------------------------------
// cvkf_div
// Bit-serial rounded fixed-point divider with saturation.
// ----------------------------------------------------------------------------
module cvkf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  cvkf_pkg::word_t num,
    input  cvkf_pkg::word_t den,
    output logic            done,
    output cvkf_pkg::word_t quo
);
    import cvkf_pkg::*;

    localparam int NW = 32 + FRAC_BITS + 2;
    localparam int CW = $clog2(NW + 1);
    localparam logic [NW-1:0] POS_LIM = NW'(64'h7FFF_FFFF);
    localparam logic [NW-1:0] NEG_LIM = NW'(64'h8000_0000);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic [NW-1:0] nsh_reg;
    logic [32:0]   d2_reg;
    logic [32:0]   rem_reg;
    logic [NW-1:0] q_reg;

    logic [31:0] mn;
    logic [31:0] md;
    logic [33:0] rem_s;
    logic [33:0] rem_d;
    logic        ge;

    always_comb begin
        mn    = num[31] ? (~num + 32'd1) : num;
        md    = den[31] ? (~den + 32'd1) : den;
        rem_s = {rem_reg, nsh_reg[NW-1]};
        rem_d = rem_s - {1'b0, d2_reg};
        ge    = rem_s >= {1'b0, d2_reg};
        if (neg_reg) begin
            quo = (q_reg > NEG_LIM) ? WORD_MIN : word_t'(~q_reg[31:0] + 32'd1);
        end else begin
            quo = (q_reg > POS_LIM) ? WORD_MAX : word_t'(q_reg[31:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
                neg_reg  <= num[31] ^ den[31];
                nsh_reg  <= (NW'(mn) << (FRAC_BITS + 1)) + NW'(md);
                d2_reg   <= {md, 1'b0};
                rem_reg  <= '0;
                q_reg    <= '0;
            end else if (busy_reg) begin
                nsh_reg <= nsh_reg << 1;
                rem_reg <= ge ? rem_d[32:0] : rem_s[32:0];
                q_reg   <= {q_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider started while busy");

endmodule

FILE: hdl/cv_kalman_track_filter_top.sv
// ----------------------------------------------------------------------------
// cv_kalman_track_filter_top
// Predict is bound by the shared multiplier (134 products). Update is
// dominated by 32 quotients of the bit-serial divider.
// One request in flight; the next is taken while the result waits.
// Reset clears state, covariance, control and restores config defaults.
// ----------------------------------------------------------------------------
module cv_kalman_track_filter_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // meas_x, meas_y, meas_vx, meas_vy, object_class, time_step
    input  logic [167:0]                     s_tdata,
    // mode
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // est_x, est_y, est_vx, est_vy
    output logic [127:0]                     m_tdata,
    // reinitialised
    output logic [0:0]                       m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cvkf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data
);
    import cvkf_pkg::*;

    localparam word_t ONE_Q   = word_t'(64'sd1 << FRAC_BITS);
    localparam wide_t VEL_LIM = 64'sd1 << (2 * FRAC_BITS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISP, ST_LOAD, ST_PX, ST_MM, ST_MMCP, ST_PQ, ST_US, ST_PIV,
        ST_NRM, ST_ELF, ST_ELM, ST_INN, ST_XN, ST_IMK, ST_VS, ST_VCHK, ST_DONE
    } state_t;

    typedef enum logic [1:0] {MM_AP, MM_PAT, MM_PINV, MM_KP} mm_sel_t;

    state_t  state_reg;
    mm_sel_t mm_sel_reg;
    logic [1:0] ms_reg, i_reg, j_reg, k_reg, c_reg, r_reg, pb_reg;
    logic [2:0] s_reg;
    logic [32:0] best_reg;
    word_t piv_reg, f_reg, dt_reg;
    wide_t acc_reg;
    logic reinit_reg;

    logic [1:0] mode_reg;
    logic [4:0] cls_reg;
    word_t ts_reg;
    word_t z_reg [4];

    word_t sv_reg [4];
    word_t cov_reg [16];
    word_t am_reg [16];
    word_t iv_reg [16];
    word_t km_reg [16];
    word_t tm_reg [16];
    word_t prow_reg [4];
    word_t pinv_reg [4];
    word_t inn_reg [4];
    logic [1:0] perm_reg [4];

    logic [30:0] noise_pos_reg, noise_vel_reg, step_min_reg, step_max_reg;
    logic [30:0] meas_n_reg [4];

    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;
    logic         m_tuser_reg;

    logic [3:0] am_addr, iv_addr, cov_addr, km_addr;
    word_t am_rd, iv_rd, cov_rd, km_rd;
    word_t op_a, op_b, mm_l, mm_r, dt_lo, dt_clamp, div_num, div_quo;
    wide_t prod, rnd, acc_sum, acc400;
    logic [1:0] k_s;
    logic [32:0] piv_mag;
    logic piv_take, div_start, div_done, vel_small;

    function automatic word_t aelem(input logic [1:0] row, input logic [1:0] col,
                                    input word_t dt);
        word_t r;
        if (row == col) begin
            r = ONE_Q;
        end else if ((row == 2'd0 && col == 2'd2) || (row == 2'd1 && col == 2'd3)) begin
            r = dt;
        end else begin
            r = '0;
        end
        return r;
    endfunction

    assign k_s = s_reg[2:1];

    always_comb begin
        am_addr  = {perm_reg[r_reg], c_reg};
        iv_addr  = {perm_reg[k_reg], j_reg};
        cov_addr = {i_reg, i_reg};
        km_addr  = {i_reg, j_reg};
        unique case (state_reg)
            ST_NRM: begin
                am_addr = {perm_reg[c_reg], k_s};
                iv_addr = {perm_reg[c_reg], k_s};
            end
            ST_ELM: begin
                am_addr = {perm_reg[r_reg], k_s};
                iv_addr = {perm_reg[r_reg], k_s};
            end
            ST_MM: begin
                cov_addr = (mm_sel_reg == MM_AP || mm_sel_reg == MM_KP) ?
                           {k_reg, j_reg} : {i_reg, k_reg};
                km_addr  = {i_reg, k_reg};
            end
            default: ;
        endcase
        am_rd  = am_reg[am_addr];
        iv_rd  = iv_reg[iv_addr];
        cov_rd = cov_reg[cov_addr];
        km_rd  = km_reg[km_addr];
    end

    always_comb begin
        unique case (mm_sel_reg)
            MM_AP:   begin mm_l = aelem(i_reg, k_reg, dt_reg); mm_r = cov_rd; end
            MM_PAT:  begin mm_l = cov_rd; mm_r = aelem(j_reg, k_reg, dt_reg); end
            MM_PINV: begin mm_l = cov_rd; mm_r = iv_rd; end
            MM_KP:   begin mm_l = km_rd; mm_r = cov_rd; end
            default: begin mm_l = '0; mm_r = '0; end
        endcase
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_PX: begin op_a = dt_reg; op_b = i_reg[0] ? sv_reg[3] : sv_reg[2]; end
            ST_MM: begin op_a = mm_l; op_b = mm_r; end
            ST_PQ: begin
                op_a = i_reg[1] ? {1'b0, noise_vel_reg} : {1'b0, noise_pos_reg};
                op_b = dt_reg;
            end
            ST_ELM: begin op_a = f_reg; op_b = s_reg[0] ? pinv_reg[k_s] : prow_reg[k_s]; end
            ST_XN: begin op_a = km_rd; op_b = inn_reg[j_reg]; end
            ST_VS: begin
                op_a = i_reg[0] ? sv_reg[3] : sv_reg[2];
                op_b = op_a;
            end
            default: ;
        endcase
    end

    always_comb begin
        dt_lo    = (ts_reg <= 0) ? {1'b0, step_min_reg} : ts_reg;
        dt_clamp = (dt_lo > $signed({1'b0, step_max_reg})) ? {1'b0, step_max_reg} : dt_lo;
        acc_sum  = acc_reg + rnd;
        piv_mag  = am_rd[31] ? (~{1'b1, am_rd} + 33'd1) : {1'b0, am_rd};
        piv_take = (r_reg == c_reg) || (piv_mag > best_reg);
        div_start = (state_reg == ST_NRM) && (ms_reg == 2'd0);
        div_num  = s_reg[0] ? iv_rd : am_rd;
        acc400   = (acc_reg <<< 8) + (acc_reg <<< 7) + (acc_reg <<< 4);
        vel_small = (sv_reg[2] > -ONE_Q) && (sv_reg[2] < ONE_Q) &&
                    (sv_reg[3] > -ONE_Q) && (sv_reg[3] < ONE_Q) && (acc400 < VEL_LIM);
    end

    cvkf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk (aclk),
        .a    (op_a),
        .b    (op_b),
        .prod (prod),
        .rnd  (rnd)
    );

    cvkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (piv_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mm_sel_reg    <= MM_AP;
            ms_reg        <= '0;
            m_tvalid_reg  <= 1'b0;
            noise_pos_reg <= 31'd65536;
            noise_vel_reg <= 31'd65536;
            step_min_reg  <= 31'd655;
            step_max_reg  <= 31'd65536;
            for (int n = 0; n < 4; n++) begin
                meas_n_reg[n] <= 31'd65536;
                sv_reg[n]     <= '0;
            end
            for (int n = 0; n < 16; n++) begin
                cov_reg[n] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_NOISE_POS: noise_pos_reg <= cfg_data[30:0];
                    CFG_NOISE_VEL: noise_vel_reg <= cfg_data[30:0];
                    CFG_MEAS_X:    meas_n_reg[0] <= cfg_data[30:0];
                    CFG_MEAS_Y:    meas_n_reg[1] <= cfg_data[30:0];
                    CFG_MEAS_VX:   meas_n_reg[2] <= cfg_data[30:0];
                    CFG_MEAS_VY:   meas_n_reg[3] <= cfg_data[30:0];
                    CFG_STEP_MIN:  step_min_reg  <= cfg_data[30:0];
                    CFG_STEP_MAX:  step_max_reg  <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg  <= s_tuser;
                        z_reg[0]  <= s_tdata[31:0];
                        z_reg[1]  <= s_tdata[63:32];
                        z_reg[2]  <= s_tdata[95:64];
                        z_reg[3]  <= s_tdata[127:96];
                        cls_reg   <= s_tdata[132:128];
                        ts_reg    <= s_tdata[164:133];
                        state_reg <= ST_DISP;
                    end
                end
                ST_DISP: begin
                    dt_reg     <= dt_clamp;
                    reinit_reg <= 1'b0;
                    ms_reg     <= '0;
                    i_reg      <= '0;
                    j_reg      <= '0;
                    k_reg      <= '0;
                    acc_reg    <= '0;
                    priority if (mode_reg == MODE_INIT ||
                                 (mode_reg == MODE_UPDATE && !class_valid(cls_reg))) begin
                        state_reg <= ST_LOAD;
                    end else if (mode_reg == MODE_PREDICT) begin
                        state_reg <= ST_PX;
                    end else if (mode_reg == MODE_UPDATE) begin
                        state_reg <= ST_US;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_LOAD: begin
                    for (int ri = 0; ri < 4; ri++) begin
                        sv_reg[ri] <= z_reg[ri];
                        for (int ci = 0; ci < 4; ci++) begin
                            cov_reg[ri*4+ci] <= (ri != ci) ? '0 :
                                (ri < 2) ? {1'b0, noise_pos_reg} : {1'b0, noise_vel_reg};
                        end
                    end
                    reinit_reg <= 1'b1;
                    state_reg  <= ST_DONE;
                end
                ST_PX: begin
                    if (ms_reg != 2'd2) begin
                        ms_reg <= ms_reg + 2'd1;
                    end else begin
                        ms_reg <= '0;
                        sv_reg[{1'b0, i_reg[0]}] <= sat32(ext(sv_reg[{1'b0, i_reg[0]}]) + rnd);
                        if (i_reg[0]) begin
                            i_reg      <= '0;
                            mm_sel_reg <= MM_AP;
                            state_reg  <= ST_MM;
                        end else begin
                            i_reg <= 2'd1;
                        end
                    end
                end
                ST_MM: begin
                    if (ms_reg != 2'd2) begin
                        ms_reg <= ms_reg + 2'd1;
                    end else begin
                        ms_reg <= '0;
                        k_reg  <= k_reg + 2'd1;
                        if (k_reg == 2'd3) begin
                            tm_reg[{i_reg, j_reg}] <= sat32(acc_sum);
                            acc_reg <= '0;
                            j_reg   <= j_reg + 2'd1;
                            if (j_reg == 2'd3) begin
                                i_reg <= i_reg + 2'd1;
                                if (i_reg == 2'd3) begin
                                    state_reg <= ST_MMCP;
                                end
                            end
                        end else begin
                            acc_reg <= acc_sum;
                        end
                    end
                end
                ST_MMCP: begin
                    for (int n = 0; n < 16; n++) begin
                        if (mm_sel_reg == MM_PINV) begin
                            km_reg[n] <= tm_reg[n];
                        end else begin
                            cov_reg[n] <= tm_reg[n];
                        end
                    end
                    i_reg   <= '0;
                    j_reg   <= '0;
                    acc_reg <= '0;
                    unique case (mm_sel_reg)
                        MM_AP: begin
                            mm_sel_reg <= MM_PAT;
                            state_reg  <= ST_MM;
                        end
                        MM_PAT:  state_reg <= ST_PQ;
                        MM_PINV: state_reg <= ST_INN;
                        MM_KP:   state_reg <= ST_VS;
                        default: state_reg <= ST_VS;
                    endcase
                end
                ST_PQ: begin
                    if (ms_reg != 2'd2) begin
                        ms_reg <= ms_reg + 2'd1;
                    end else begin
                        ms_reg <= '0;
                        cov_reg[{i_reg, i_reg}] <=
                            sat32(ext(cov_reg[{i_reg, i_reg}]) + ext(sat32(rnd)));
                        i_reg <= i_reg + 2'd1;
                        if (i_reg == 2'd3) begin
                            cov_reg[2]  <= '0;
                            cov_reg[3]  <= '0;
                            cov_reg[8]  <= '0;
                            cov_reg[12] <= '0;
                            state_reg   <= ST_DONE;
                        end
                    end
                end
                ST_US: begin
                    for (int ri = 0; ri < 4; ri++) begin
                        perm_reg[ri] <= 2'(ri);
                        for (int ci = 0; ci < 4; ci++) begin
                            am_reg[ri*4+ci] <= (ri != ci) ? cov_reg[ri*4+ci] :
                                sat32(ext(cov_reg[ri*4+ci]) + ext({1'b0, meas_n_reg[ri]}));
                            iv_reg[ri*4+ci] <= (ri == ci) ? ONE_Q : '0;
                        end
                    end
                    c_reg     <= '0;
                    r_reg     <= '0;
                    state_reg <= ST_PIV;
                end
                ST_PIV: begin
                    if (piv_take) begin
                        best_reg <= piv_mag;
                        pb_reg   <= r_reg;
                        piv_reg  <= am_rd;
                    end
                    if (r_reg == 2'd3) begin
                        if ((piv_take ? piv_mag : best_reg) == 33'd0) begin
                            i_reg     <= '0;
                            acc_reg   <= '0;
                            state_reg <= ST_VS;
                        end else begin
                            if ((piv_take ? r_reg : pb_reg) != c_reg) begin
                                perm_reg[c_reg] <= perm_reg[piv_take ? r_reg : pb_reg];
                                perm_reg[piv_take ? r_reg : pb_reg] <= perm_reg[c_reg];
                            end
                            s_reg     <= '0;
                            ms_reg    <= '0;
                            state_reg <= ST_NRM;
                        end
                    end else begin
                        r_reg <= r_reg + 2'd1;
                    end
                end
                ST_NRM: begin
                    if (ms_reg == 2'd0) begin
                        ms_reg <= 2'd1;
                    end else if (div_done) begin
                        ms_reg <= '0;
                        if (s_reg[0]) begin
                            iv_reg[iv_addr] <= div_quo;
                            pinv_reg[k_s]   <= div_quo;
                        end else begin
                            am_reg[am_addr] <= div_quo;
                            prow_reg[k_s]   <= div_quo;
                        end
                        s_reg <= s_reg + 3'd1;
                        if (s_reg == 3'd7) begin
                            r_reg     <= '0;
                            state_reg <= ST_ELF;
                        end
                    end
                end
                ST_ELF, ST_ELM: begin
                    if (state_reg == ST_ELF && r_reg != c_reg) begin
                        f_reg     <= am_rd;
                        s_reg     <= '0;
                        ms_reg    <= '0;
                        state_reg <= ST_ELM;
                    end else if (state_reg == ST_ELM && ms_reg != 2'd2) begin
                        ms_reg <= ms_reg + 2'd1;
                    end else begin
                        if (state_reg == ST_ELM) begin
                            ms_reg <= '0;
                            if (s_reg[0]) begin
                                iv_reg[iv_addr] <= sat32(ext(iv_rd) - rnd);
                            end else begin
                                am_reg[am_addr] <= sat32(ext(am_rd) - rnd);
                            end
                            s_reg <= s_reg + 3'd1;
                        end
                        if (state_reg == ST_ELF || s_reg == 3'd7) begin
                            if (r_reg == 2'd3) begin
                                if (c_reg == 2'd3) begin
                                    i_reg      <= '0;
                                    j_reg      <= '0;
                                    k_reg      <= '0;
                                    acc_reg    <= '0;
                                    mm_sel_reg <= MM_PINV;
                                    state_reg  <= ST_MM;
                                end else begin
                                    c_reg     <= c_reg + 2'd1;
                                    r_reg     <= c_reg + 2'd1;
                                    state_reg <= ST_PIV;
                                end
                            end else begin
                                r_reg     <= r_reg + 2'd1;
                                state_reg <= ST_ELF;
                            end
                        end
                    end
                end
                ST_INN: begin
                    for (int n = 0; n < 4; n++) begin
                        inn_reg[n] <= sat32(ext(z_reg[n]) - ext(sv_reg[n]));
                    end
                    state_reg <= ST_XN;
                end
                ST_XN: begin
                    if (ms_reg != 2'd2) begin
                        ms_reg <= ms_reg + 2'd1;
                    end else begin
                        ms_reg <= '0;
                        j_reg  <= j_reg + 2'd1;
                        if (j_reg == 2'd3) begin
                            sv_reg[i_reg] <= sat32(ext(sv_reg[i_reg]) + ext(sat32(acc_sum)));
                            acc_reg <= '0;
                            i_reg   <= i_reg + 2'd1;
                            if (i_reg == 2'd3) begin
                                state_reg <= ST_IMK;
                            end
                        end else begin
                            acc_reg <= acc_sum;
                        end
                    end
                end
                ST_IMK: begin
                    for (int ri = 0; ri < 4; ri++) begin
                        for (int ci = 0; ci < 4; ci++) begin
                            km_reg[ri*4+ci] <= sat32(ext((ri == ci) ? ONE_Q : '0) -
                                                     ext(km_reg[ri*4+ci]));
                        end
                    end
                    i_reg      <= '0;
                    j_reg      <= '0;
                    k_reg      <= '0;
                    acc_reg    <= '0;
                    mm_sel_reg <= MM_KP;
                    state_reg  <= ST_MM;
                end
                ST_VS: begin
                    if (ms_reg != 2'd2) begin
                        ms_reg <= ms_reg + 2'd1;
                    end else begin
                        ms_reg  <= '0;
                        acc_reg <= acc_reg + prod;
                        if (i_reg[0]) begin
                            state_reg <= ST_VCHK;
                        end else begin
                            i_reg <= 2'd1;
                        end
                    end
                end
                ST_VCHK: begin
                    if (vel_small) begin
                        sv_reg[2] <= '0;
                        sv_reg[3] <= '0;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {sv_reg[3], sv_reg[2], sv_reg[1], sv_reg[0]};
                        m_tuser_reg  <= reinit_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("accepted while busy");

    a_perm_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NRM || state_reg == ST_ELF || state_reg == ST_ELM) |->
        (perm_reg[0] != perm_reg[1] && perm_reg[0] != perm_reg[2] &&
         perm_reg[0] != perm_reg[3] && perm_reg[1] != perm_reg[2] &&
         perm_reg[1] != perm_reg[3] && perm_reg[2] != perm_reg[3]))
        else $error("row order is not a permutation");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

    a_div_done_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_NRM && ms_reg == 2'd1))
        else $error("quotient arrived while not waiting");

endmodule

FILE: bench/cv_kalman_track_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv_kalman_track_filter_checker
// Watches the request, result and configuration channels of the track
// filter. It keeps its own copy of the estimate, covariance and registers,
// works out the estimate for every accepted request and compares each
// returned result field by field against the oldest outstanding estimate.
// ----------------------------------------------------------------------------
module cv_kalman_track_filter_checker
    import cvkf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [167:0]         s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [127:0]         m_tdata,
    input  logic [0:0]           m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output int                   fails,
    output int                   pending
);

    localparam longint ONE_Q = 64'sd65536;

    typedef int mat16_t [16];

    typedef struct packed {
        logic [31:0] est_x;
        logic [31:0] est_y;
        logic [31:0] est_vx;
        logic [31:0] est_vy;
        logic        reinit;
    } estimate_t;

    estimate_t est_queue [$];

    int noise_pos, noise_vel, step_lo, step_hi;
    int meas_noise [4];
    int trk_state [4];
    mat16_t trk_cov;

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    function automatic longint fx_mul(int a, int b);
        longint p, m;
        p = longint'(a) * longint'(b);
        m = (p < 0) ? -p : p;
        m = (m + 64'sd32768) >>> 16;
        return (p < 0) ? -m : m;
    endfunction

    function automatic int fx_div(int n, int d);
        longint mn, md, q;
        mn = (n < 0) ? -longint'(n) : longint'(n);
        md = (d < 0) ? -longint'(d) : longint'(d);
        q = ((mn <<< 17) + md) / (md <<< 1);
        return clip32(((n < 0) != (d < 0)) ? -q : q);
    endfunction

    function automatic mat16_t mat_mul(mat16_t a, mat16_t b);
        mat16_t t;
        longint s;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                s = 0;
                for (int k = 0; k < 4; k++) s += fx_mul(a[i*4+k], b[k*4+j]);
                t[i*4+j] = clip32(s);
            end
        end
        return t;
    endfunction

    function automatic bit mat_inv(mat16_t s, output mat16_t inv);
        mat16_t a;
        int p, piv, f, tmp;
        longint best, m;
        a = s;
        for (int i = 0; i < 16; i++) inv[i] = (i % 5 == 0) ? int'(ONE_Q) : 0;
        for (int c = 0; c < 4; c++) begin
            p = c;
            best = (a[c*5] < 0) ? -longint'(a[c*5]) : longint'(a[c*5]);
            for (int r = c + 1; r < 4; r++) begin
                m = (a[r*4+c] < 0) ? -longint'(a[r*4+c]) : longint'(a[r*4+c]);
                if (m > best) begin
                    best = m;
                    p = r;
                end
            end
            if (best == 0) return 1'b0;
            if (p != c) begin
                for (int k = 0; k < 4; k++) begin
                    tmp = a[c*4+k]; a[c*4+k] = a[p*4+k]; a[p*4+k] = tmp;
                    tmp = inv[c*4+k]; inv[c*4+k] = inv[p*4+k]; inv[p*4+k] = tmp;
                end
            end
            piv = a[c*5];
            for (int k = 0; k < 4; k++) begin
                a[c*4+k] = fx_div(a[c*4+k], piv);
                inv[c*4+k] = fx_div(inv[c*4+k], piv);
            end
            for (int r = 0; r < 4; r++) begin
                if (r != c) begin
                    f = a[r*4+c];
                    for (int k = 0; k < 4; k++) begin
                        a[r*4+k] = clip32(longint'(a[r*4+k]) - fx_mul(f, a[c*4+k]));
                        inv[r*4+k] = clip32(longint'(inv[r*4+k]) - fx_mul(f, inv[c*4+k]));
                    end
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void load_track(int z [4]);
        trk_state = z;
        for (int i = 0; i < 16; i++) trk_cov[i] = 0;
        trk_cov[0] = noise_pos;
        trk_cov[5] = noise_pos;
        trk_cov[10] = noise_vel;
        trk_cov[15] = noise_vel;
    endfunction

    function automatic void predict_track(int step);
        mat16_t a, at;
        longint ts;
        int dt;
        ts = step;
        if (ts <= 0) ts = step_lo;
        if (ts > step_hi) ts = step_hi;
        dt = int'(ts);
        for (int i = 0; i < 16; i++) a[i] = (i % 5 == 0) ? int'(ONE_Q) : 0;
        a[2] = dt;
        a[7] = dt;
        for (int i = 0; i < 16; i++) at[(i % 4) * 4 + i / 4] = a[i];
        trk_state[0] = clip32(longint'(trk_state[0]) + fx_mul(dt, trk_state[2]));
        trk_state[1] = clip32(longint'(trk_state[1]) + fx_mul(dt, trk_state[3]));
        trk_cov = mat_mul(a, trk_cov);
        trk_cov = mat_mul(trk_cov, at);
        for (int i = 0; i < 4; i++) begin
            trk_cov[i*5] = clip32(longint'(trk_cov[i*5]) +
                clip32(fx_mul((i < 2) ? noise_pos : noise_vel, dt)));
        end
        trk_cov[2] = 0;
        trk_cov[3] = 0;
        trk_cov[8] = 0;
        trk_cov[12] = 0;
    endfunction

    function automatic void correct_track(int z [4]);
        mat16_t s, inv, gain;
        int innov [4];
        int xn [4];
        longint acc, vx, vy;
        s = trk_cov;
        for (int i = 0; i < 4; i++) s[i*5] = clip32(longint'(s[i*5]) + longint'(meas_noise[i]));
        if (mat_inv(s, inv)) begin
            gain = mat_mul(trk_cov, inv);
            for (int i = 0; i < 4; i++) innov[i] = clip32(longint'(z[i]) - trk_state[i]);
            for (int i = 0; i < 4; i++) begin
                acc = 0;
                for (int j = 0; j < 4; j++) acc += fx_mul(gain[i*4+j], innov[j]);
                xn[i] = clip32(longint'(trk_state[i]) + clip32(acc));
            end
            trk_state = xn;
            for (int i = 0; i < 16; i++)
                gain[i] = clip32(((i % 5 == 0) ? ONE_Q : 0) - longint'(gain[i]));
            trk_cov = mat_mul(gain, trk_cov);
        end
        vx = trk_state[2];
        vy = trk_state[3];
        if (vx > -ONE_Q && vx < ONE_Q && vy > -ONE_Q && vy < ONE_Q) begin
            if (400 * (vx * vx + vy * vy) < (64'sd1 <<< 32)) begin
                trk_state[2] = 0;
                trk_state[3] = 0;
            end
        end
    endfunction

    function automatic estimate_t step_track(logic [167:0] d, logic [1:0] mode);
        estimate_t e;
        int z [4];
        for (int i = 0; i < 4; i++) z[i] = d[i*32 +: 32];
        e.reinit = 1'b0;
        if (mode == MODE_INIT) begin
            load_track(z);
            e.reinit = 1'b1;
        end else if (mode == MODE_PREDICT) begin
            predict_track(d[164:133]);
        end else if (mode == MODE_UPDATE) begin
            if (!class_valid(d[132:128])) begin
                load_track(z);
                e.reinit = 1'b1;
            end else begin
                correct_track(z);
            end
        end
        e.est_x = trk_state[0];
        e.est_y = trk_state[1];
        e.est_vx = trk_state[2];
        e.est_vy = trk_state[3];
        return e;
    endfunction

    function automatic int field_err(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v === act_v) return 0;
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge aclk) begin
        estimate_t e;
        int bad;
        if (!aresetn) begin
            noise_pos = 65536;
            noise_vel = 65536;
            meas_noise = '{65536, 65536, 65536, 65536};
            step_lo = 655;
            step_hi = 65536;
            trk_state = '{0, 0, 0, 0};
            for (int i = 0; i < 16; i++) trk_cov[i] = 0;
            est_queue.delete();
            fails = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NOISE_POS: noise_pos = {1'b0, cfg_data[30:0]};
                    CFG_NOISE_VEL: noise_vel = {1'b0, cfg_data[30:0]};
                    CFG_MEAS_X:    meas_noise[0] = {1'b0, cfg_data[30:0]};
                    CFG_MEAS_Y:    meas_noise[1] = {1'b0, cfg_data[30:0]};
                    CFG_MEAS_VX:   meas_noise[2] = {1'b0, cfg_data[30:0]};
                    CFG_MEAS_VY:   meas_noise[3] = {1'b0, cfg_data[30:0]};
                    CFG_STEP_MIN:  step_lo = {1'b0, cfg_data[30:0]};
                    CFG_STEP_MAX:  step_hi = {1'b0, cfg_data[30:0]};
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (est_queue.size() == 0) begin
                    $display("%0t: result with no request outstanding, actual %h %b",
                             $time, m_tdata, m_tuser);
                    fails++;
                end else begin
                    e = est_queue.pop_front();
                    bad = field_err("est_x", e.est_x, m_tdata[31:0]) +
                          field_err("est_y", e.est_y, m_tdata[63:32]) +
                          field_err("est_vx", e.est_vx, m_tdata[95:64]) +
                          field_err("est_vy", e.est_vy, m_tdata[127:96]) +
                          field_err("reinitialised", e.reinit, m_tuser[0]);
                    if (bad != 0) fails++;
                end
            end
            if (s_tvalid && s_tready) est_queue.push_back(step_track(s_tdata, s_tuser));
        end
        pending = est_queue.size();
    end

endmodule

FILE: bench/cv_kalman_track_filter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv_kalman_track_filter_top_tb
// Drives init, predict and update requests into the track filter across
// several register settings and handshake idling patterns, including a long
// result back-pressure stretch, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module cv_kalman_track_filter_top_tb;
    import cvkf_pkg::*;

    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 155;
    localparam int CYCLE_LIMIT = 12000000;
    localparam int DRAIN_CYCLES = 3000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [167:0]         s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [127:0]         m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int fails;
    int pending;
    int cycles;
    int idle_mode;
    int hold_cycles;
    int track_left;

    cv_kalman_track_filter_top uut (.*);

    cv_kalman_track_filter_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                hold_cycles--;
            end else if (idle_mode == 2) begin
                m_tready = ($urandom_range(99) >= 45);
            end else if (idle_mode == 3) begin
                m_tready = ($urandom_range(99) >= 9);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    function automatic logic [31:0] rand_q(bit wide);
        if (wide) return $urandom;
        return $urandom_range(32'h0040_0000) - 32'h0020_0000;
    endfunction

    function automatic logic [4:0] rand_valid_class();
        case ($urandom_range(2))
            0: return 5'($urandom_range(7, 1));
            1: return 5'($urandom_range(17, 15));
            default: return 5'($urandom_range(21, 20));
        endcase
    endfunction

    task automatic send_request(logic [1:0] mode, logic [31:0] x, logic [31:0] y,
                                logic [31:0] vx, logic [31:0] vy,
                                logic [4:0] cls, logic [31:0] ts);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 45 : (idle_mode == 3) ? 9 : 0;
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = {3'b000, ts, cls, vy, vx, y, x};
        s_tuser = mode;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge aclk);
        s_tvalid = 1'b0;
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic setup_phase(int ph);
        logic [31:0] vals [8];
        case (ph)
            0: vals = '{65536, 65536, 65536, 65536, 65536, 65536, 655, 65536};
            1: vals = '{0, 0, 0, 0, 0, 0, 1, 1};
            2: vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
            3: vals = '{1, 2, 3, 4, 5, 6, 32'h0004_0000, 32'h0000_8000};
            default: begin
                for (int i = 0; i < 6; i++) vals[i] = $urandom_range(32'h0008_0000);
                vals[6] = $urandom_range(32'h0000_4000, 1);
                vals[7] = $urandom_range(32'h0002_0000, 32'h0000_4000);
            end
        endcase
        for (int i = 0; i < 8; i++) write_reg(i[CFG_IDX_W-1:0], vals[i]);
    endtask

    task automatic directed_requests();
        send_request(MODE_UPDATE, 0, 0, 0, 0, 5'd1, 0);
        send_request(MODE_INIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 5'd31, 32'hFFFF_FFFF);
        send_request(MODE_PREDICT, 0, 0, 0, 0, 5'd0, 32'h8000_0000);
        send_request(MODE_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 5'd0, 32'h7FFF_FFFF);
        send_request(MODE_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 5'd21, 0);
        send_request(MODE_UPDATE, 0, 0, 0, 0, 5'd0, 0);
        send_request(MODE_INIT, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0C00,
                     32'hFFFF_F400, 5'd0, 0);
        send_request(MODE_PREDICT, 0, 0, 0, 0, 5'd0, 0);
        send_request(MODE_UPDATE, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0C00,
                     32'hFFFF_F400, 5'd15, 0);
        send_request(MODE_UPDATE, 32'h0001_0000, 0, 32'h0000_0CCD, 0, 5'd8, 0);
        send_request(2'd3, $urandom, $urandom, $urandom, $urandom, 5'd31, $urandom);
        send_request(MODE_UPDATE, 0, 0, 32'h0000_0CCC, 0, 5'd7, 0);
        send_request(MODE_UPDATE, 0, 0, 0, 0, 5'd14, 0);
        send_request(MODE_UPDATE, 0, 0, 0, 0, 5'd18, 0);
        send_request(MODE_UPDATE, 0, 0, 0, 0, 5'd19, 0);
        send_request(MODE_UPDATE, 0, 0, 0, 0, 5'd22, 0);
        send_request(MODE_PREDICT, 0, 0, 0, 0, 5'd0, 32'h0000_0001);
        send_request(MODE_UPDATE, 32'h0010_0000, 32'h0020_0000, 32'h0001_0000,
                     32'hFFFF_0000, 5'd16, 0);
        send_request(MODE_UPDATE, 32'h0010_0000, 32'h0020_0000, 32'h0001_0000,
                     32'hFFFF_0000, 5'd20, 0);
    endtask

    task automatic random_request();
        bit wide;
        logic [4:0] cls;
        wide = ($urandom_range(9) == 0);
        if ($urandom_range(99) < 8) begin
            send_request(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
                         5'($urandom_range(31)), $urandom);
        end else if (track_left == 0) begin
            send_request(MODE_INIT, rand_q(wide), rand_q(wide), rand_q(wide),
                         rand_q(wide), 5'($urandom_range(31)), $urandom);
            track_left = $urandom_range(12, 3);
        end else begin
            track_left--;
            if ($urandom_range(99) < 62) begin
                send_request(MODE_PREDICT, $urandom, $urandom, $urandom, $urandom,
                             5'($urandom_range(31)),
                             wide ? $urandom : $urandom_range(32'h0002_0000) - 32'h0000_1000);
            end else begin
                cls = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) : rand_valid_class();
                send_request(MODE_UPDATE, rand_q(wide), rand_q(wide), rand_q(wide),
                             rand_q(wide), cls, $urandom);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MODE_INIT;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_mode = 0;
        hold_cycles = 0;
        track_left = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            setup_phase(ph);
            idle_mode = ph % 4;
            track_left = 0;
            if (ph == 0 || ph == 1) directed_requests();
            if (ph == 2) hold_cycles = 4000;
            for (int n = 0; n < PHASE_ITEMS; n++) random_request();
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fails == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
